>>> sv/fcfe_pkg.sv
// ----------------------------------------------------------------------------
// fcfe_pkg
// Shared constants and controller/datapath interface types of the
// front-coded form encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fcfe_pkg;

  localparam int unsigned MAX_STRING_LEN = 61;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned LEN_W          = $clog2(MAX_STRING_LEN + 1);
  localparam int unsigned ADDR_W         = $clog2(MAX_STRING_LEN);
  localparam int unsigned IN_USER_W      = 3;

  // Bit positions within the input tuser.
  localparam int unsigned USER_BYTE_VALID = 0;
  localparam int unsigned USER_IS_REF     = 1;
  localparam int unsigned USER_KEY_END    = 2;

  // Header format limits.
  localparam int unsigned SHARED_LIM = 16;
  localparam int unsigned SUFFIX_LIM = 8;
  localparam logic [BYTE_W-1:0] LONG_HDR_FLAG = 8'h80;
  localparam logic [BYTE_W-1:0] TERM_BYTE     = 8'h00;

  typedef struct packed {
    logic accept;     // latch input item, issue previous-string read
    logic update;     // compare and store the latched character
    logic finish;     // current string becomes the previous string
    logic load_hdr1;  // load first header byte into output register
    logic load_hdr2;  // load second header byte
    logic rd_suf;     // issue current-string read at suffix index
    logic load_suf;   // load suffix byte, advance index
    logic load_term;  // load zero terminator
    logic out_last;   // mark loaded byte as last of run
  } cmd_t;

  typedef struct packed {
    logic slot_free;   // output register can take a byte this cycle
    logic str_end;
    logic is_ref;
    logic key_end;
    logic one_hdr;     // header fits in one byte
    logic suffix_zero;
    logic idx_last;    // suffix index points at last character
  } status_t;

endpackage

`default_nettype wire

>>> sv/front_coded_form_encoder_unit.sv
// ----------------------------------------------------------------------------
// front_coded_form_encoder_unit
// Front-coding encoder for the forms of one dictionary key.
// ----------------------------------------------------------------------------
// Strings arrive one character per input item; tlast closes a string. The
// first string of a key (tuser is_reference on its closing item) is stored
// and yields no output. Every later string (a form) is compared against the
// string before it; when it closes, the block emits a header byte
// (suffix_len<<4 | shared_len) or, if that does not fit, the pair
// 0x80|shared_len, suffix_len+1, then the differing suffix bytes, then a
// zero byte if tuser key_end is set. m_axis_tlast marks the last byte of
// each burst. Strings are held to 61 characters; extra characters are
// dropped and every byte of that form carries too_long in m_axis_tuser.
// A zero character, or an item with byte_valid low, carries no character.
// Each input item needs a registered read of the previous string, then
// compare and store, before the next item is taken. Closing a lemma adds a
// step that makes it the previous string. Closing a form adds a step per
// header byte, a registered read of the string buffer and a load per suffix
// byte, and a step for the terminator, each load waiting while the output
// register is busy. Two ping-pong string buffers swap roles at the end of a
// string, so there is no copy and no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module front_coded_form_encoder_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic [2:0] s_axis_tuser,   // [0] byte_valid, [1] is_reference, [2] key_end
  input  wire logic       s_axis_tlast,   // string_end
  // Output stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tuser,   // [0] too_long
  output logic            m_axis_tlast    // last_of_run
);
  import fcfe_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Sequence byte updates and the emission of each form.
  fcfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold strings, counters and the output register.
  fcfe_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_byte_i       (s_axis_tdata),
    .in_byte_valid_i (s_axis_tuser[USER_BYTE_VALID]),
    .in_is_ref_i     (s_axis_tuser[USER_IS_REF]),
    .in_str_end_i    (s_axis_tlast),
    .in_key_end_i    (s_axis_tuser[USER_KEY_END]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_byte_o      (m_axis_tdata),
    .out_too_long_o  (m_axis_tuser),
    .out_last_o      (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> sv/fcfe_ram.sv
// ----------------------------------------------------------------------------
// fcfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/fcfe_ctrl.sv
// ----------------------------------------------------------------------------
// fcfe_ctrl
// Sequencer: per-byte compare/store, then header, suffix and terminator
// emission at the end of each form.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fcfe_pkg::status_t sts_i,
  output fcfe_pkg::cmd_t         cmd_o
);
  import fcfe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_HDR1 = 3'd2;
  localparam logic [2:0] S_HDR2 = 3'd3;
  localparam logic [2:0] S_SADR = 3'd4;
  localparam logic [2:0] S_SOUT = 3'd5;
  localparam logic [2:0] S_TERM = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.str_end ? S_HDR1 : S_IDLE;
      end
      S_HDR1: begin
        if (sts_i.is_ref) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.load_hdr1 = 1'b1;
          if (!sts_i.one_hdr) begin
            state_d = S_HDR2;
          end else if (!sts_i.suffix_zero) begin
            state_d = S_SADR;
          end else if (sts_i.key_end) begin
            state_d = S_TERM;
          end else begin
            cmd_o.out_last = 1'b1;
            cmd_o.finish   = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      S_HDR2: begin
        if (sts_i.slot_free) begin
          cmd_o.load_hdr2 = 1'b1;
          if (!sts_i.suffix_zero) begin
            state_d = S_SADR;
          end else if (sts_i.key_end) begin
            state_d = S_TERM;
          end else begin
            cmd_o.out_last = 1'b1;
            cmd_o.finish   = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      S_SADR: begin
        cmd_o.rd_suf = 1'b1;
        state_d      = S_SOUT;
      end
      S_SOUT: begin
        if (sts_i.slot_free) begin
          cmd_o.load_suf = 1'b1;
          if (!sts_i.idx_last) begin
            state_d = S_SADR;
          end else if (sts_i.key_end) begin
            state_d = S_TERM;
          end else begin
            cmd_o.out_last = 1'b1;
            cmd_o.finish   = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (sts_i.slot_free) begin
          cmd_o.load_term = 1'b1;
          cmd_o.out_last  = 1'b1;
          cmd_o.finish    = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/fcfe_dp.sv
// ----------------------------------------------------------------------------
// fcfe_dp
// Datapath: ping-pong string buffers, length and match counters, header
// formatting and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfe_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [fcfe_pkg::BYTE_W-1:0]    in_byte_i,
  input  wire logic                          in_byte_valid_i,
  input  wire logic                          in_is_ref_i,
  input  wire logic                          in_str_end_i,
  input  wire logic                          in_key_end_i,
  input  wire fcfe_pkg::cmd_t                cmd_i,
  output fcfe_pkg::status_t                  sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [fcfe_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                               out_too_long_o,
  output logic                               out_last_o
);
  import fcfe_pkg::*;

  // Latched input item.
  logic [BYTE_W-1:0] byte_q;
  logic              has_char_q, str_end_q, is_ref_q, key_end_q;

  // String state.
  logic [LEN_W-1:0]  cur_len_q, prev_len_q, shared_q, idx_q;
  logic              match_q, ovf_q, bank_q;

  // Output register.
  logic              out_valid_q, out_last_q, out_too_long_q;
  logic [BYTE_W-1:0] out_byte_q;

  logic [BYTE_W-1:0] rdata0, rdata1, prev_rd, cur_rd;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              cur_room, wr_en, rd_prev, rd_cur;
  logic [LEN_W-1:0]  suffix, idx_next;
  logic              one_hdr;
  logic [BYTE_W-1:0] hdr1, hdr2, load_byte;
  logic              load_any;

  assign cur_room = cur_len_q < LEN_W'(MAX_STRING_LEN);
  assign wr_en    = cmd_i.update && has_char_q && cur_room;
  assign wr_addr  = cur_len_q[ADDR_W-1:0];
  assign rd_prev  = cmd_i.accept && cur_room;
  assign rd_cur   = cmd_i.rd_suf;
  assign rd_addr  = cmd_i.accept ? cur_len_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

  // bank_q selects the buffer holding the current string.
  fcfe_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_STRING_LEN)) u_buf0 (
    .clk_i   (clk_i),
    .we_i    (wr_en && !bank_q),
    .waddr_i (wr_addr),
    .wdata_i (byte_q),
    .re_i    ((rd_prev && bank_q) || (rd_cur && !bank_q)),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  fcfe_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_STRING_LEN)) u_buf1 (
    .clk_i   (clk_i),
    .we_i    (wr_en && bank_q),
    .waddr_i (wr_addr),
    .wdata_i (byte_q),
    .re_i    ((rd_prev && !bank_q) || (rd_cur && bank_q)),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  assign prev_rd = bank_q ? rdata0 : rdata1;
  assign cur_rd  = bank_q ? rdata1 : rdata0;

  // Header formatting.
  assign suffix   = cur_len_q - shared_q;
  assign one_hdr  = (shared_q < LEN_W'(SHARED_LIM)) && (suffix < LEN_W'(SUFFIX_LIM)) &&
                    ((shared_q != '0) || (suffix != '0));
  assign hdr1     = one_hdr ? {1'b0, suffix[2:0], shared_q[3:0]}
                            : (LONG_HDR_FLAG | BYTE_W'(shared_q));
  assign hdr2     = BYTE_W'(suffix) + BYTE_W'(1);
  assign idx_next = idx_q + LEN_W'(1);

  always_comb begin
    load_byte = TERM_BYTE;
    if (cmd_i.load_hdr1) begin
      load_byte = hdr1;
    end else if (cmd_i.load_hdr2) begin
      load_byte = hdr2;
    end else if (cmd_i.load_suf) begin
      load_byte = cur_rd;
    end
  end

  assign load_any = cmd_i.load_hdr1 || cmd_i.load_hdr2 || cmd_i.load_suf || cmd_i.load_term;

  assign sts_o.slot_free   = !out_valid_q || out_ready_i;
  assign sts_o.str_end     = str_end_q;
  assign sts_o.is_ref      = is_ref_q;
  assign sts_o.key_end     = key_end_q;
  assign sts_o.one_hdr     = one_hdr;
  assign sts_o.suffix_zero = suffix == '0;
  assign sts_o.idx_last    = idx_next == cur_len_q;

  // Input latch and output payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q     <= in_byte_i;
      has_char_q <= in_byte_valid_i && (in_byte_i != '0);
      str_end_q  <= in_str_end_i;
      is_ref_q   <= in_is_ref_i;
      key_end_q  <= in_key_end_i;
    end
    if (load_any) begin
      out_byte_q     <= load_byte;
      out_too_long_q <= ovf_q;
      out_last_q     <= cmd_i.out_last;
    end
    if (cmd_i.load_hdr1) begin
      idx_q <= shared_q;
    end else if (cmd_i.load_suf) begin
      idx_q <= idx_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q   <= '0;
      prev_len_q  <= '0;
      shared_q    <= '0;
      match_q     <= 1'b1;
      ovf_q       <= 1'b0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update && has_char_q) begin
        if (cur_room) begin
          if (match_q && (cur_len_q < prev_len_q) && (prev_rd == byte_q)) begin
            shared_q <= shared_q + LEN_W'(1);
          end else begin
            match_q <= 1'b0;
          end
          cur_len_q <= cur_len_q + LEN_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        bank_q     <= !bank_q;
        prev_len_q <= cur_len_q;
        cur_len_q  <= '0;
        shared_q   <= '0;
        match_q    <= 1'b1;
        ovf_q      <= 1'b0;
      end
      if (load_any) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_too_long_o = out_too_long_q;
  assign out_last_o     = out_last_q;

endmodule

`default_nettype wire
